@@ hdl/jdm_pkg.sv @@
// Shared types, constants and arithmetic helpers for the joystick drive mixer.
package jdm_pkg;

   localparam int ChanWidth  = 8;
   localparam int CountWidth = 7;
   localparam int DbWidth    = 13;
   localparam int DriveWidth = 14;
   localparam int ModeWidth  = 3;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 13;
   localparam int ReqDataWidth = 40;
   localparam int RspDataWidth = 48;

   localparam logic [ModeWidth-1:0]  ModeMax    = 3'd5;
   localparam logic [ChanWidth-1:0]  ArmFullUp  = 8'd255;
   localparam logic [ChanWidth-1:0]  ArmStop    = 8'd127;
   localparam logic [ChanWidth-1:0]  ArmFullDn  = 8'd0;
   localparam logic [ChanWidth-1:0]  LevelMax   = 8'd254;

   // Register reset values.
   localparam logic [7:0]  RstBtnRev   = 8'd100;
   localparam logic [7:0]  RstBtnFwd   = 8'd154;
   localparam logic [7:0]  RstArmUp    = 8'd170;
   localparam logic [7:0]  RstArmDown  = 8'd90;
   localparam logic [12:0] RstDeadband = 13'd255;
   localparam logic [6:0]  RstConfirm  = 7'd5;
   localparam logic [6:0]  RstRepeat   = 7'd100;
   localparam logic [7:0]  RstHandOpen = 8'd200;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_BTN_REV   = 3'd0,
      CSR_BTN_FWD   = 3'd1,
      CSR_ARM_UP    = 3'd2,
      CSR_ARM_DOWN  = 3'd3,
      CSR_DEADBAND  = 3'd4,
      CSR_CONFIRM   = 3'd5,
      CSR_REPEAT    = 3'd6,
      CSR_HAND_OPEN = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_REV  = 2'd1,
      ACT_FWD  = 2'd2,
      ACT_HOLD = 2'd3
   } btn_act_type;

   typedef struct packed {
      logic [ChanWidth-1:0]  rev_thresh;
      logic [ChanWidth-1:0]  fwd_thresh;
      logic [CountWidth-1:0] confirm;
      logic [CountWidth-1:0] repeat_limit;
   } btn_cfg_type;

   // Arcade mix of two sticks into one side's level, clamped to 0..254.
   // neg_turn selects throttle - turn + 127 instead of turn + throttle - 127.
   function automatic logic [ChanWidth-1:0] mix_level(
      input logic [ChanWidth-1:0] turn,
      input logic [ChanWidth-1:0] thr,
      input logic                 neg_turn
   );
      logic signed [9:0] t;
      logic signed [9:0] h;
      logic signed [9:0] s;
      logic [ChanWidth-1:0] r;
      t = signed'({2'b00, turn});
      h = signed'({2'b00, thr});
      if (neg_turn) begin
         s = h - t + 10'sd127;
      end else begin
         s = h + t - 10'sd127;
      end
      if (s < 10'sd0) begin
         r = '0;
      end else if (s > 10'sd254) begin
         r = LevelMax;
      end else begin
         r = s[ChanWidth-1:0];
      end
      return r;
   endfunction

   // Level to drive in 1/5100 units, (255 - 2*level)*20, then the deadband.
   function automatic logic signed [DriveWidth-1:0] drive_of(
      input logic [ChanWidth-1:0] level,
      input logic [DbWidth-1:0]   db
   );
      logic signed [14:0] lv;
      logic signed [14:0] v;
      logic signed [14:0] d;
      logic signed [14:0] r;
      lv = signed'({7'd0, level});
      v  = (15'sd255 - (lv <<< 1)) * 15'sd20;
      d  = signed'({2'b00, db});
      if (v < -d) begin
         r = v + d;
      end else if (v > d) begin
         r = v - d;
      end else begin
         r = '0;
      end
      return r[DriveWidth-1:0];
   endfunction

endpackage

@@ hdl/jdm_debounce.sv @@
// Button press counter with confirm count and auto-repeat for one receiver channel.
module jdm_debounce (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [jdm_pkg::ChanWidth-1:0]      chan,
   input  jdm_pkg::btn_cfg_type               cfg,
   output jdm_pkg::btn_act_type               act
);

   logic [jdm_pkg::CountWidth-1:0] count_ff;
   logic [jdm_pkg::CountWidth-1:0] count_in;
   logic [jdm_pkg::CountWidth-1:0] count_base;
   logic                           press_rev;
   logic                           press_fwd;

   always_comb begin
      count_base = (count_ff > cfg.repeat_limit) ? '0 : count_ff;
      press_rev  = chan < cfg.rev_thresh;
      press_fwd  = chan > cfg.fwd_thresh;
      if (press_rev || press_fwd) begin
         count_in = count_base + 7'd1;
         if (count_in != cfg.confirm) begin
            act = jdm_pkg::ACT_HOLD;
         end else if (press_rev) begin
            // Reverse wins when both thresholds are met.
            act = jdm_pkg::ACT_REV;
         end else begin
            act = jdm_pkg::ACT_FWD;
         end
      end else begin
         count_in = '0;
         act      = jdm_pkg::ACT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (step) begin
         count_ff <= count_in;
      end
   end

endmodule

@@ hdl/joystick_drive_mixer_unit.sv @@
// Top level of the joystick drive mixer: stick mix, arm mapping, button state.
//
//   Port group  Dir  Contents
//   req_*       in   one receiver frame per beat (five 8-bit channels)
//   rsp_*       out  one drive result per beat
//   csr_*       in   register writes, no read-back
//
// An accepted frame is held in the input register, is mixed and updates the
// button state on its way into the result register, and is then offered on
// rsp; one frame per cycle is sustained while rsp is not stalled. A stalled rsp
// holds the result register and then the input register; req_tready stays high
// while the input register is empty or moving. Synchronous reset clears valids,
// button counters, mode and hand level, and loads the register defaults.
module joystick_drive_mixer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // stick_turn[7:0], stick_throttle[15:8], arm_stick[23:16],
   // mode_button[31:24], hand_button[39:32]
   input  logic [jdm_pkg::ReqDataWidth-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // right_drive[13:0], left_drive[27:14], arm_drive[35:28],
   // hand_drive[43:36], mode_now[46:44], zero[47]
   output logic [jdm_pkg::RspDataWidth-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [jdm_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [jdm_pkg::CsrDataWidth-1:0]     csr_wdata
);

   // Configuration registers.
   logic [7:0]  btn_rev_ff;
   logic [7:0]  btn_fwd_ff;
   logic [7:0]  arm_up_ff;
   logic [7:0]  arm_down_ff;
   logic [12:0] deadband_ff;
   logic [6:0]  confirm_ff;
   logic [6:0]  repeat_ff;
   logic [7:0]  hand_open_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         btn_rev_ff   <= jdm_pkg::RstBtnRev;
         btn_fwd_ff   <= jdm_pkg::RstBtnFwd;
         arm_up_ff    <= jdm_pkg::RstArmUp;
         arm_down_ff  <= jdm_pkg::RstArmDown;
         deadband_ff  <= jdm_pkg::RstDeadband;
         confirm_ff   <= jdm_pkg::RstConfirm;
         repeat_ff    <= jdm_pkg::RstRepeat;
         hand_open_ff <= jdm_pkg::RstHandOpen;
      end else if (csr_we) begin
         case (jdm_pkg::csr_index_type'(csr_index))
            jdm_pkg::CSR_BTN_REV:   btn_rev_ff   <= csr_wdata[7:0];
            jdm_pkg::CSR_BTN_FWD:   btn_fwd_ff   <= csr_wdata[7:0];
            jdm_pkg::CSR_ARM_UP:    arm_up_ff    <= csr_wdata[7:0];
            jdm_pkg::CSR_ARM_DOWN:  arm_down_ff  <= csr_wdata[7:0];
            jdm_pkg::CSR_DEADBAND:  deadband_ff  <= csr_wdata[12:0];
            jdm_pkg::CSR_CONFIRM:   confirm_ff   <= csr_wdata[6:0];
            jdm_pkg::CSR_REPEAT:    repeat_ff    <= csr_wdata[6:0];
            jdm_pkg::CSR_HAND_OPEN: hand_open_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Input register and handshake.
   logic                                 in_valid_ff;
   logic [jdm_pkg::ReqDataWidth-1:0]     in_data_ff;
   logic                                 rsp_valid_ff;
   logic [jdm_pkg::RspDataWidth-1:0]     rsp_data_ff;
   logic                                 out_load;
   logic                                 req_take;

   assign out_load   = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_tdata;
      end
   end

   // Field unpacking.
   logic [7:0] stick_turn;
   logic [7:0] stick_throttle;
   logic [7:0] arm_stick;
   logic [7:0] mode_button;
   logic [7:0] hand_button;

   assign stick_turn     = in_data_ff[7:0];
   assign stick_throttle = in_data_ff[15:8];
   assign arm_stick      = in_data_ff[23:16];
   assign mode_button    = in_data_ff[31:24];
   assign hand_button    = in_data_ff[39:32];

   // Drive mix.
   logic signed [jdm_pkg::DriveWidth-1:0] right_raw;
   logic signed [jdm_pkg::DriveWidth-1:0] left_raw;
   logic signed [jdm_pkg::DriveWidth-1:0] right_drive;
   logic signed [jdm_pkg::DriveWidth-1:0] left_drive;
   logic [7:0]                            arm_drive;

   always_comb begin
      right_raw = jdm_pkg::drive_of(
         jdm_pkg::mix_level(stick_turn, stick_throttle, 1'b0), deadband_ff);
      left_raw  = jdm_pkg::drive_of(
         jdm_pkg::mix_level(stick_turn, stick_throttle, 1'b1), deadband_ff);
      // Sides that would turn against each other: right is cleared first, then
      // left is tested against the updated right.
      right_drive = (left_raw < 0 && right_raw > 0) ? '0 : right_raw;
      left_drive  = (right_drive < 0 && left_raw > 0) ? '0 : left_raw;

      if (arm_stick > arm_up_ff) begin
         arm_drive = jdm_pkg::ArmFullUp;
      end else if (arm_stick < arm_down_ff) begin
         arm_drive = jdm_pkg::ArmFullDn;
      end else begin
         arm_drive = jdm_pkg::ArmStop;
      end
   end

   // Buttons.
   jdm_pkg::btn_cfg_type btn_cfg;
   jdm_pkg::btn_act_type mode_act;
   jdm_pkg::btn_act_type hand_act;

   assign btn_cfg = '{rev_thresh: btn_rev_ff, fwd_thresh: btn_fwd_ff,
                      confirm: confirm_ff, repeat_limit: repeat_ff};

   jdm_debounce u_mode_btn (
      .clock (clock),
      .reset (reset),
      .step  (out_load),
      .chan  (mode_button),
      .cfg   (btn_cfg),
      .act   (mode_act)
   );

   jdm_debounce u_hand_btn (
      .clock (clock),
      .reset (reset),
      .step  (out_load),
      .chan  (hand_button),
      .cfg   (btn_cfg),
      .act   (hand_act)
   );

   logic [jdm_pkg::ModeWidth-1:0] mode_ff;
   logic [jdm_pkg::ModeWidth-1:0] mode_in;
   logic [7:0]                    hand_ff;
   logic [7:0]                    hand_in;

   always_comb begin
      case (mode_act)
         jdm_pkg::ACT_REV:
            mode_in = (mode_ff == '0) ? jdm_pkg::ModeMax : mode_ff - 3'd1;
         jdm_pkg::ACT_FWD:
            mode_in = (mode_ff == jdm_pkg::ModeMax) ? '0 : mode_ff + 3'd1;
         default:
            mode_in = mode_ff;
      endcase
      case (hand_act)
         jdm_pkg::ACT_REV: hand_in = hand_open_ff;
         jdm_pkg::ACT_FWD: hand_in = '0;
         default:          hand_in = hand_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         hand_ff <= '0;
      end else if (out_load) begin
         mode_ff <= mode_in;
         hand_ff <= hand_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {1'b0, mode_in, hand_in, arm_drive,
                         left_drive, right_drive};
      end
   end

endmodule
